// ----- rtl/gbs_pkg.sv -----
package gbs_pkg;

  localparam int COORD_BITS    = 13;
  localparam int SCORE_BITS    = 16;
  localparam int LABEL_BITS    = 8;
  localparam int THR_BITS      = 17;
  localparam int FRAC_BITS     = 16;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int EXT_BITS      = COORD_BITS + 1;
  localparam int AREA_BITS     = 2 * EXT_BITS;
  localparam int UNI_BITS      = AREA_BITS + 1;
  localparam int PROD_BITS     = UNI_BITS + THR_BITS;

  localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(29491);

  // register index taken from paddr above the byte offset
  localparam logic [CFG_ADDR_BITS-3:0] REG_THRESHOLD = '0;

  typedef struct packed {
    logic                  has_box;
    logic [COORD_BITS-1:0] left_x;
    logic [COORD_BITS-1:0] top_y;
    logic [COORD_BITS-1:0] right_x;
    logic [COORD_BITS-1:0] bottom_y;
    logic [SCORE_BITS-1:0] confidence;
    logic [LABEL_BITS-1:0] class_label;
    logic                  frame_end;
  } box_in_t;

  typedef struct packed {
    logic                  box_present;
    logic [COORD_BITS-1:0] kept_left_x;
    logic [COORD_BITS-1:0] kept_top_y;
    logic [COORD_BITS-1:0] kept_right_x;
    logic [COORD_BITS-1:0] kept_bottom_y;
    logic [SCORE_BITS-1:0] kept_confidence;
    logic [LABEL_BITS-1:0] kept_label;
    logic                  last_kept;
    logic                  dropped_overflow;
  } box_out_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] left_x;
    logic [COORD_BITS-1:0] top_y;
    logic [COORD_BITS-1:0] right_x;
    logic [COORD_BITS-1:0] bottom_y;
    logic [SCORE_BITS-1:0] score;
    logic [LABEL_BITS-1:0] label;
  } box_rec_t;

  typedef struct packed {
    logic done;
    logic hit;
  } ovl_res_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_R_I,
    ST_R_IW,
    ST_R_J,
    ST_R_JW,
    ST_I_ORD,
    ST_I_CHK,
    ST_I_BOX,
    ST_I_EMIT,
    ST_J_ORD,
    ST_J_CHK,
    ST_J_BOX,
    ST_J_WAIT,
    ST_FLUSH,
    ST_EMPTY
  } state_t;

  function automatic logic [EXT_BITS-1:0] extent(input logic [COORD_BITS-1:0] lo,
                                                 input logic [COORD_BITS-1:0] hi);
    extent = (hi >= lo) ? (EXT_BITS'(hi) - EXT_BITS'(lo) + EXT_BITS'(1)) : '0;
  endfunction

  function automatic box_out_t make_out(input box_rec_t rec, input logic last,
                                        input logic ovf);
    box_out_t o;
    o.box_present      = 1'b1;
    o.kept_left_x      = rec.left_x;
    o.kept_top_y       = rec.top_y;
    o.kept_right_x     = rec.right_x;
    o.kept_bottom_y    = rec.bottom_y;
    o.kept_confidence  = rec.score;
    o.kept_label       = rec.label;
    o.last_kept        = last;
    o.dropped_overflow = ovf;
    make_out = o;
  endfunction

endpackage

// ----- rtl/gbs_stream_if.sv -----
interface gbs_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ----- rtl/gbs_overlap.sv -----
module gbs_overlap (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  gbs_pkg::box_rec_t               box_a,
  input  gbs_pkg::box_rec_t               box_b,
  input  logic [gbs_pkg::THR_BITS-1:0]    thr,
  output gbs_pkg::ovl_res_t               res
);
  import gbs_pkg::*;

  logic [3:0]           v_r;
  logic [EXT_BITS-1:0]  iw_r, ih_r, aw_r, ah_r, bw_r, bh_r;
  logic [AREA_BITS-1:0] inter_r, area_a_r, area_b_r, inter3_r, inter4_r;
  logic [UNI_BITS-1:0]  uni_r;
  logic [PROD_BITS-1:0] prod_r;
  logic                 nz4_r;
  logic [COORD_BITS-1:0] x1, y1, x2, y2;

  always_comb begin
    x1 = (box_a.left_x   > box_b.left_x)   ? box_a.left_x   : box_b.left_x;
    y1 = (box_a.top_y    > box_b.top_y)    ? box_a.top_y    : box_b.top_y;
    x2 = (box_a.right_x  < box_b.right_x)  ? box_a.right_x  : box_b.right_x;
    y2 = (box_a.bottom_y < box_b.bottom_y) ? box_a.bottom_y : box_b.bottom_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    iw_r     <= extent(x1, x2);
    ih_r     <= extent(y1, y2);
    aw_r     <= extent(box_a.left_x, box_a.right_x);
    ah_r     <= extent(box_a.top_y, box_a.bottom_y);
    bw_r     <= extent(box_b.left_x, box_b.right_x);
    bh_r     <= extent(box_b.top_y, box_b.bottom_y);
    inter_r  <= AREA_BITS'(iw_r) * AREA_BITS'(ih_r);
    area_a_r <= AREA_BITS'(aw_r) * AREA_BITS'(ah_r);
    area_b_r <= AREA_BITS'(bw_r) * AREA_BITS'(bh_r);
    uni_r    <= UNI_BITS'(area_a_r) + UNI_BITS'(area_b_r) - UNI_BITS'(inter_r);
    inter3_r <= inter_r;
    prod_r   <= PROD_BITS'(thr) * PROD_BITS'(uni_r);
    inter4_r <= inter3_r;
    nz4_r    <= (uni_r != '0);
  end

  // cross-multiplied ratio test, zero union never overlaps
  assign res.done = v_r[3];
  assign res.hit  = nz4_r && (PROD_BITS'({inter4_r, FRAC_BITS'(0)}) >= prod_r);

endmodule

// ----- rtl/greedy_box_suppression_unit.sv -----
// loading: one box per cycle, an input transfer each clock while the frame is open
// after frame close: ranking compares each box with every box over the box memory read port
// suppression: each kept box is emitted, then tested against every later unsuppressed entry; output stalls can hold it
// throughput: one frame at a time, input held off from frame close until the last result
// is loaded into the output register
// reset: synchronous active-low rst_n clears control and counts and sets the threshold to 29491
module greedy_box_suppression_unit #(
  parameter int MAX_BOXES = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  gbs_stream_if.sink                        in_ch,
  gbs_stream_if.source                      out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gbs_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [gbs_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [gbs_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import gbs_pkg::*;

  localparam int IW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);

  state_t             state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt, n_r, n_nxt, i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0]      rank_r, rank_nxt, i_inc, j_inc, cnt_after;
  logic               ovf_r, ovf_nxt, pend_valid_r, pend_valid_nxt;
  logic [THR_BITS-1:0] thr_r;
  logic [SCORE_BITS-1:0] si_r, si_nxt;
  box_rec_t           a_r, a_nxt, pend_r, pend_nxt;
  logic [IW-1:0]      idxj_r, idxj_nxt;
  logic               out_valid_r, out_valid_nxt, out_free, beat;
  box_out_t           out_data_r, out_data_nxt;

  // box memory and order memory ({suppressed, box index} by rank)
  box_rec_t           box_mem [MAX_BOXES];
  logic [IW:0]        ord_mem [MAX_BOXES];
  box_rec_t           box_q, box_wdata;
  logic [IW:0]        ord_q, ord_wdata;
  logic [IW-1:0]      box_raddr, box_waddr, ord_raddr, ord_waddr;
  logic               box_we, ord_we, ovl_start, cfg_wr;
  ovl_res_t           ovl_res;

  always_ff @(posedge clk) begin
    if (box_we) begin
      box_mem[box_waddr] <= box_wdata;
    end
    box_q <= box_mem[box_raddr];
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_q <= ord_mem[ord_raddr];
  end

  gbs_overlap u_overlap (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ovl_start),
    .box_a (a_r),
    .box_b (box_q),
    .thr   (thr_r),
    .res   (ovl_res)
  );

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[CFG_ADDR_BITS-1:2] == REG_THRESHOLD) ?
                  CFG_DATA_BITS'(thr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr && (paddr[CFG_ADDR_BITS-1:2] == REG_THRESHOLD)) begin
      thr_r <= pwdata[THR_BITS-1:0];
    end
  end

  assign in_ch.ready  = (state_r == ST_LOAD);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign i_inc        = i_r + CW'(1);
  assign j_inc        = j_r + CW'(1);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    n_nxt          = n_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    rank_nxt       = rank_r;
    ovf_nxt        = ovf_r;
    si_nxt         = si_r;
    a_nxt          = a_r;
    pend_nxt       = pend_r;
    pend_valid_nxt = pend_valid_r;
    idxj_nxt       = idxj_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_data_nxt   = out_data_r;
    box_raddr      = '0;
    ord_raddr      = '0;
    box_we         = 1'b0;
    box_waddr      = cnt_r[IW-1:0];
    box_wdata      = '{in_ch.data.left_x, in_ch.data.top_y, in_ch.data.right_x,
                       in_ch.data.bottom_y, in_ch.data.confidence,
                       in_ch.data.class_label};
    ord_we         = 1'b0;
    ord_waddr      = j_r[IW-1:0];
    ord_wdata      = {1'b1, idxj_r};
    ovl_start      = 1'b0;
    cnt_after      = cnt_r;
    beat           = 1'b0;

    case (state_r)
      ST_LOAD: begin
        if (in_ch.valid) begin
          if (in_ch.data.has_box) begin
            if (cnt_r < CW'(MAX_BOXES)) begin
              box_we    = 1'b1;
              cnt_after = cnt_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          cnt_nxt = cnt_after;
          if (in_ch.data.frame_end) begin
            n_nxt     = cnt_after;
            i_nxt     = '0;
            state_nxt = (cnt_after == '0) ? ST_EMPTY : ST_R_I;
          end
        end
      end
      // rank of box i: boxes with higher score, or equal score and earlier arrival
      ST_R_I: begin
        box_raddr = i_r[IW-1:0];
        state_nxt = ST_R_IW;
      end
      ST_R_IW: begin
        si_nxt    = box_q.score;
        j_nxt     = '0;
        rank_nxt  = '0;
        state_nxt = ST_R_J;
      end
      ST_R_J: begin
        box_raddr = j_r[IW-1:0];
        state_nxt = ST_R_JW;
      end
      ST_R_JW: begin
        beat     = (box_q.score > si_r) || ((box_q.score == si_r) && (j_r < i_r));
        rank_nxt = rank_r + CW'(beat);
        j_nxt    = j_inc;
        if (j_inc == n_r) begin
          ord_we    = 1'b1;
          ord_waddr = rank_nxt[IW-1:0];
          ord_wdata = {1'b0, i_r[IW-1:0]};
          i_nxt     = i_inc;
          state_nxt = ST_R_I;
          if (i_inc == n_r) begin
            i_nxt     = '0;
            state_nxt = ST_I_ORD;
          end
        end else begin
          state_nxt = ST_R_J;
        end
      end
      ST_I_ORD: begin
        ord_raddr = i_r[IW-1:0];
        state_nxt = ST_I_CHK;
      end
      ST_I_CHK: begin
        if (ord_q[IW]) begin
          i_nxt     = i_inc;
          state_nxt = (i_inc == n_r) ? ST_FLUSH : ST_I_ORD;
        end else begin
          box_raddr = ord_q[IW-1:0];
          state_nxt = ST_I_BOX;
        end
      end
      ST_I_BOX: begin
        a_nxt     = box_q;
        state_nxt = ST_I_EMIT;
      end
      // a kept box goes out one behind so the final one can carry last_kept
      ST_I_EMIT: begin
        if (!pend_valid_r || out_free) begin
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = make_out(pend_r, 1'b0, ovf_r);
          end
          pend_nxt       = a_r;
          pend_valid_nxt = 1'b1;
          j_nxt          = i_inc;
          if (i_inc == n_r) begin
            state_nxt = ST_FLUSH;
          end else begin
            state_nxt = ST_J_ORD;
          end
        end
      end
      ST_J_ORD: begin
        ord_raddr = j_r[IW-1:0];
        state_nxt = ST_J_CHK;
      end
      ST_J_CHK: begin
        if (ord_q[IW]) begin
          j_nxt = j_inc;
          if (j_inc == n_r) begin
            i_nxt     = i_inc;
            state_nxt = ST_I_ORD;
          end else begin
            state_nxt = ST_J_ORD;
          end
        end else begin
          box_raddr = ord_q[IW-1:0];
          idxj_nxt  = ord_q[IW-1:0];
          state_nxt = ST_J_BOX;
        end
      end
      ST_J_BOX: begin
        ovl_start = 1'b1;
        state_nxt = ST_J_WAIT;
      end
      ST_J_WAIT: begin
        if (ovl_res.done) begin
          ord_we = ovl_res.hit;
          j_nxt  = j_inc;
          if (j_inc == n_r) begin
            i_nxt     = i_inc;
            state_nxt = ST_I_ORD;
          end else begin
            state_nxt = ST_J_ORD;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = make_out(pend_r, 1'b1, ovf_r);
          pend_valid_nxt = 1'b0;
          cnt_nxt        = '0;
          ovf_nxt        = 1'b0;
          state_nxt      = ST_LOAD;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt                  = '0;
          out_data_nxt.last_kept        = 1'b1;
          out_data_nxt.dropped_overflow = ovf_r;
          cnt_nxt                       = '0;
          ovf_nxt                       = 1'b0;
          state_nxt                     = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      n_r          <= '0;
      i_r          <= '0;
      j_r          <= '0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      ovf_r        <= ovf_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      n_r          <= n_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rank_r     <= rank_nxt;
    si_r       <= si_nxt;
    a_r        <= a_nxt;
    pend_r     <= pend_nxt;
    idxj_r     <= idxj_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- rtl/gbs_checker.sv -----
module gbs_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_frame_end,
  input logic                              out_valid,
  input logic                              out_ready,
  input gbs_pkg::box_out_t                 out_data,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [gbs_pkg::CFG_ADDR_BITS-1:0] paddr,
  input logic [gbs_pkg::CFG_DATA_BITS-1:0] pwdata,
  input logic [gbs_pkg::CFG_DATA_BITS-1:0] prdata,
  input logic                              pready
);
  import gbs_pkg::*;

  // input closes once a frame-end transfer is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_frame_end) |=> !in_ready)
    else $error("input still open after frame end");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.box_present) |-> out_data.last_kept)
    else $error("empty-frame result not marked last");

  assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && pready && (paddr[CFG_ADDR_BITS-1:2] == REG_THRESHOLD))
    ##1 (!pwrite && (paddr[CFG_ADDR_BITS-1:2] == REG_THRESHOLD))
    |-> (prdata[THR_BITS-1:0] == $past(pwdata[THR_BITS-1:0])))
    else $error("threshold readback mismatch");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind greedy_box_suppression_unit gbs_checker u_gbs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_frame_end (in_ch.data.frame_end),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_data     (out_ch.data),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata),
  .pready       (pready)
);
